FILE: rtl/cube_map_face_uv_select_assert.svh
// ----------------------------------------------------------------------------
// Cube map face select assertion macros
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_FACE_UV_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_UV_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CUBEUV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed delay set by n, disabled while reset is high.
`define CUBEUV_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

FILE: rtl/cubeuv_pkg.sv
// ----------------------------------------------------------------------------
// Cube map face select package
// Face codes, pipeline control beat type and default widths.
// ----------------------------------------------------------------------------
package cubeuv_pkg;

   localparam int COMPONENT_BITS_DEFAULT = 16;
   localparam int COORD_BITS_DEFAULT     = 16;
   localparam int FACE_MASK_BITS         = 6;

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // Control that travels alongside the divider data through every cell.
   typedef struct packed {
      logic     valid;
      logic     zero;
      logic     texture;
      logic     sat_u;
      logic     sat_v;
      face_type face;
   } ctl_type;

endpackage

FILE: rtl/cubeuv_front.sv
// ----------------------------------------------------------------------------
// Cube map face select front stage
// Picks the major axis and face, forms the u and v dividends and the divisor.
// ----------------------------------------------------------------------------
module cubeuv_front #(
   parameter int COMPONENT_BITS = cubeuv_pkg::COMPONENT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  logic [COMPONENT_BITS-1:0]              dir_x,
   input  logic [COMPONENT_BITS-1:0]              dir_y,
   input  logic [COMPONENT_BITS-1:0]              dir_z,
   input  logic [cubeuv_pkg::FACE_MASK_BITS-1:0]  face_mask,
   output cubeuv_pkg::ctl_type                    ctl_ff,
   output logic [COMPONENT_BITS:0]                den_ff,
   output logic [COMPONENT_BITS:0]                top_u_ff,
   output logic [COMPONENT_BITS:0]                top_v_ff
);

   localparam int CB = COMPONENT_BITS;
   localparam logic [CB-1:0] ONE = {{(CB-1){1'b0}}, 1'b1};

   logic [CB-1:0]        ax, ay, az, m;
   logic signed [CB:0]   xe, ye, ze, nu, nv, m_s;
   logic signed [CB+1:0] sum_u, sum_v;
   logic                 x_pos, y_pos, z_pos;
   cubeuv_pkg::face_type face;
   cubeuv_pkg::ctl_type  ctl_in;

   always_comb begin
      ax = dir_x[CB-1] ? (~dir_x + ONE) : dir_x;
      ay = dir_y[CB-1] ? (~dir_y + ONE) : dir_y;
      az = dir_z[CB-1] ? (~dir_z + ONE) : dir_z;
      xe = signed'({dir_x[CB-1], dir_x});
      ye = signed'({dir_y[CB-1], dir_y});
      ze = signed'({dir_z[CB-1], dir_z});
      x_pos = !dir_x[CB-1] && (dir_x != '0);
      y_pos = !dir_y[CB-1] && (dir_y != '0);
      z_pos = !dir_z[CB-1] && (dir_z != '0);

      if (ax >= ay && ax >= az) begin
         m  = ax;
         nv = -ye;
         if (x_pos) begin
            face = cubeuv_pkg::FACE_POS_X;
            nu   = -ze;
         end else begin
            face = cubeuv_pkg::FACE_NEG_X;
            nu   = ze;
         end
      end else if (ay >= ax && ay >= az) begin
         m  = ay;
         nu = xe;
         if (y_pos) begin
            face = cubeuv_pkg::FACE_POS_Y;
            nv   = ze;
         end else begin
            face = cubeuv_pkg::FACE_NEG_Y;
            nv   = -ze;
         end
      end else begin
         m  = az;
         nv = -ye;
         if (z_pos) begin
            face = cubeuv_pkg::FACE_POS_Z;
            nu   = xe;
         end else begin
            face = cubeuv_pkg::FACE_NEG_Z;
            nu   = -xe;
         end
      end

      m_s   = signed'({1'b0, m});
      sum_u = signed'({nu[CB], nu}) + signed'({2'b00, m});
      sum_v = signed'({nv[CB], nv}) + signed'({2'b00, m});

      ctl_in.valid   = accept;
      ctl_in.zero    = (m == '0);
      ctl_in.texture = face_mask[face];
      // A numerator equal to the magnitude gives exactly 1.0, which saturates.
      ctl_in.sat_u   = (nu >= m_s);
      ctl_in.sat_v   = (nv >= m_s);
      ctl_in.face    = face;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      den_ff   <= {m, 1'b0};
      top_u_ff <= sum_u[CB:0];
      top_v_ff <= sum_v[CB:0];
   end

endmodule

FILE: rtl/cubeuv_cell.sv
// ----------------------------------------------------------------------------
// Cube map face select divider cell
// One restoring step for both u and v: one quotient bit per lane per cell.
// ----------------------------------------------------------------------------
module cubeuv_cell #(
   parameter int COMPONENT_BITS = cubeuv_pkg::COMPONENT_BITS_DEFAULT,
   parameter int COORD_BITS     = cubeuv_pkg::COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cubeuv_pkg::ctl_type       ctl_in,
   input  logic [COMPONENT_BITS:0]   den_in,
   input  logic [COMPONENT_BITS:0]   rem_u_in,
   input  logic [COMPONENT_BITS:0]   rem_v_in,
   input  logic [COORD_BITS-1:0]     q_u_in,
   input  logic [COORD_BITS-1:0]     q_v_in,
   output cubeuv_pkg::ctl_type       ctl_ff,
   output logic [COMPONENT_BITS:0]   den_ff,
   output logic [COMPONENT_BITS:0]   rem_u_ff,
   output logic [COMPONENT_BITS:0]   rem_v_ff,
   output logic [COORD_BITS-1:0]     q_u_ff,
   output logic [COORD_BITS-1:0]     q_v_ff
);

   localparam int CB = COMPONENT_BITS;

   logic [CB+1:0] shl_u, shl_v, den_ext, dif_u, dif_v;
   logic          ge_u, ge_v;

   always_comb begin
      den_ext = {1'b0, den_in};
      shl_u   = {rem_u_in, 1'b0};
      shl_v   = {rem_v_in, 1'b0};
      dif_u   = shl_u - den_ext;
      dif_v   = shl_v - den_ext;
      ge_u    = (shl_u >= den_ext);
      ge_v    = (shl_v >= den_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      den_ff   <= den_in;
      rem_u_ff <= ge_u ? dif_u[CB:0] : shl_u[CB:0];
      rem_v_ff <= ge_v ? dif_v[CB:0] : shl_v[CB:0];
      q_u_ff   <= {q_u_in[COORD_BITS-2:0], ge_u};
      q_v_ff   <= {q_v_in[COORD_BITS-2:0], ge_v};
   end

endmodule

FILE: rtl/cube_map_face_uv_select.sv
// ----------------------------------------------------------------------------
// Cube map face selection and face coordinates
// Maps a signed direction vector to a cube face and its u, v coordinates.
// ----------------------------------------------------------------------------
// Usage:
// A direction beat is taken at every rising edge with start high and busy
// low. Busy is always low, so a new direction may enter on every clock and
// the block sustains one beat per cycle.
// The front stage picks the major axis (ties go to X, then Y), the face and
// the two dividends and registers them. A chain of COORD_BITS divider cells
// then produces one quotient bit per cell for u and v side by side; a result
// passes the front register and every cell register before it leaves.
// Each result is shown for exactly one cycle with rsp_valid high; the
// receiver cannot stall the chain, so no back pressure exists anywhere.
// While rsp_valid is low all result ports read zero.
// The face present mask is written over the csr channel, which is always
// ready; it should be written only while no direction is in flight.
// Synchronous reset empties the pipeline and clears the mask to zero.
// ----------------------------------------------------------------------------
module cube_map_face_uv_select #(
   parameter int COMPONENT_BITS = cubeuv_pkg::COMPONENT_BITS_DEFAULT,
   parameter int COORD_BITS     = cubeuv_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [COMPONENT_BITS-1:0]              req_dir_x,
   input  logic [COMPONENT_BITS-1:0]              req_dir_y,
   input  logic [COMPONENT_BITS-1:0]              req_dir_z,
   output logic                                   rsp_valid,
   output logic [2:0]                             rsp_face_index,
   output logic [COORD_BITS-1:0]                  rsp_u_coord,
   output logic [COORD_BITS-1:0]                  rsp_v_coord,
   output logic                                   rsp_texture_present,
   output logic                                   rsp_zero_direction,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cubeuv_pkg::FACE_MASK_BITS-1:0]  csr_wdata
);

   localparam int CB = COMPONENT_BITS;
   localparam int QB = COORD_BITS;

   logic [cubeuv_pkg::FACE_MASK_BITS-1:0] face_mask_ff, face_mask_in;

   // Stage k of the chain feeds cell k; the last entry holds the finished beat.
   cubeuv_pkg::ctl_type ctl_chain   [0:QB];
   logic [CB:0]         den_chain   [0:QB];
   logic [CB:0]         rem_u_chain [0:QB];
   logic [CB:0]         rem_v_chain [0:QB];
   logic [QB-1:0]       q_u_chain   [0:QB];
   logic [QB-1:0]       q_v_chain   [0:QB];

   cubeuv_pkg::ctl_type ctl_out;
   logic                live;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign face_mask_in = (csr_valid && csr_ready) ? csr_wdata : face_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_mask_ff <= '0;
      end else begin
         face_mask_ff <= face_mask_in;
      end
   end

   cubeuv_front #(
      .COMPONENT_BITS (CB)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .dir_x     (req_dir_x),
      .dir_y     (req_dir_y),
      .dir_z     (req_dir_z),
      .face_mask (face_mask_ff),
      .ctl_ff    (ctl_chain[0]),
      .den_ff    (den_chain[0]),
      .top_u_ff  (rem_u_chain[0]),
      .top_v_ff  (rem_v_chain[0])
   );

   // The quotient registers start empty; every bit is shifted in by a cell.
   assign q_u_chain[0] = '0;
   assign q_v_chain[0] = '0;

   for (genvar k = 0; k < QB; k++) begin : g_cell
      cubeuv_cell #(
         .COMPONENT_BITS (CB),
         .COORD_BITS     (QB)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl_chain[k]),
         .den_in   (den_chain[k]),
         .rem_u_in (rem_u_chain[k]),
         .rem_v_in (rem_v_chain[k]),
         .q_u_in   (q_u_chain[k]),
         .q_v_in   (q_v_chain[k]),
         .ctl_ff   (ctl_chain[k+1]),
         .den_ff   (den_chain[k+1]),
         .rem_u_ff (rem_u_chain[k+1]),
         .rem_v_ff (rem_v_chain[k+1]),
         .q_u_ff   (q_u_chain[k+1]),
         .q_v_ff   (q_v_chain[k+1])
      );
   end

   // The zero vector overrides everything, and a quotient of exactly one
   // saturates to all ones; the divider value is ignored in both cases.
   assign ctl_out = ctl_chain[QB];
   assign live    = ctl_out.valid && !ctl_out.zero;

   assign rsp_valid           = ctl_out.valid;
   assign rsp_zero_direction  = ctl_out.valid && ctl_out.zero;
   assign rsp_face_index      = live ? ctl_out.face : 3'd0;
   assign rsp_texture_present = live && ctl_out.texture;
   assign rsp_u_coord = !live ? '0 : (ctl_out.sat_u ? '1 : q_u_chain[QB]);
   assign rsp_v_coord = !live ? '0 : (ctl_out.sat_v ? '1 : q_v_chain[QB]);

endmodule

FILE: rtl/cube_map_face_uv_select_checker.sv
// ----------------------------------------------------------------------------
// Cube map face select checker
// Port-level checks on latency, zero vector results and quiet outputs.
// ----------------------------------------------------------------------------
`include "cube_map_face_uv_select_assert.svh"

module cube_map_face_uv_select_checker #(
   parameter int COMPONENT_BITS = cubeuv_pkg::COMPONENT_BITS_DEFAULT,
   parameter int COORD_BITS     = cubeuv_pkg::COORD_BITS_DEFAULT
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic [COMPONENT_BITS-1:0]              req_dir_x,
   input logic [COMPONENT_BITS-1:0]              req_dir_y,
   input logic [COMPONENT_BITS-1:0]              req_dir_z,
   input logic                                   rsp_valid,
   input logic [2:0]                             rsp_face_index,
   input logic [COORD_BITS-1:0]                  rsp_u_coord,
   input logic [COORD_BITS-1:0]                  rsp_v_coord,
   input logic                                   rsp_texture_present,
   input logic                                   rsp_zero_direction
);

   localparam int LATENCY = COORD_BITS + 1;

   // Every accepted beat comes out after the front stage and the cell chain.
   `CUBEUV_ASSERT_DELAY(a_latency, clock, reset, start && !busy, LATENCY, rsp_valid, "result beat missing after fixed latency")

   // An all-zero direction gives the flag and nothing else.
   `CUBEUV_ASSERT_IMPL(a_zero_result, clock, reset, rsp_valid && rsp_zero_direction, rsp_face_index == 3'd0 && rsp_u_coord == '0 && rsp_v_coord == '0 && !rsp_texture_present, "zero direction with nonzero fields")

   // A zero flag on the result is only possible for an all-zero direction.
   `CUBEUV_ASSERT_DELAY(a_zero_source, clock, reset, start && !busy && (req_dir_x != '0 || req_dir_y != '0 || req_dir_z != '0), LATENCY, !rsp_zero_direction, "zero flag for a nonzero direction")

   // Between result beats the result ports stay quiet.
   `CUBEUV_ASSERT_IMPL(a_quiet, clock, reset, !rsp_valid, rsp_face_index == 3'd0 && rsp_u_coord == '0 && rsp_v_coord == '0 && !rsp_texture_present && !rsp_zero_direction, "result ports active without a result beat")

endmodule

bind cube_map_face_uv_select cube_map_face_uv_select_checker #(
   .COMPONENT_BITS (COMPONENT_BITS),
   .COORD_BITS     (COORD_BITS)
) u_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_dir_x           (req_dir_x),
   .req_dir_y           (req_dir_y),
   .req_dir_z           (req_dir_z),
   .rsp_valid           (rsp_valid),
   .rsp_face_index      (rsp_face_index),
   .rsp_u_coord         (rsp_u_coord),
   .rsp_v_coord         (rsp_v_coord),
   .rsp_texture_present (rsp_texture_present),
   .rsp_zero_direction  (rsp_zero_direction)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cube map face select testbench
// Sends direction beats to the face selector, predicts the face, u, v and
// texture flag of every beat, and compares each result beat as it leaves.
// ----------------------------------------------------------------------------
module tb;

   localparam int CB = cubeuv_pkg::COMPONENT_BITS_DEFAULT;
   localparam int QB = cubeuv_pkg::COORD_BITS_DEFAULT;
   localparam int MB = cubeuv_pkg::FACE_MASK_BITS;

   // The drain wait covers the front stage and the divider chain, plus a little slack.
   localparam int DRAIN_CYCLES = QB + 8;
   localparam int RANDOM_PHASES = 6;
   localparam int BEATS_PER_PHASE = 275;
   localparam int MAX_REPORTS = 60;

   // One expected result beat.
   typedef struct {
      cubeuv_pkg::face_type  face;
      logic [QB-1:0]         u_coord;
      logic [QB-1:0]         v_coord;
      logic                  texture_present;
      logic                  zero_direction;
   } face_uv_type;

   // Keeps the expected result beats in order of acceptance, together with
   // its own copy of the face present mask, and checks the beats that leave.
   class face_uv_scoreboard;
      face_uv_type    expected_q[$];
      logic [MB-1:0]  face_mask;
      int             mismatches;

      function new();
         face_mask  = '0;
         mismatches = 0;
      endfunction

      function void set_mask(logic [MB-1:0] mask);
         face_mask = mask;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // floor(((num + mag) / (2 mag)) * 2^QB); a ratio of exactly one saturates.
      function logic [QB-1:0] face_coord(longint num, longint mag);
         longint span;
         longint den;
         span = num + mag;
         den  = 2 * mag;
         if (span >= den)
            return '1;
         return QB'((span << QB) / den);
      endfunction

      function face_uv_type predict_face_uv(shortint x, shortint y, shortint z);
         face_uv_type beat;
         longint      ax, ay, az, mag, nu, nv;
         ax = (x < 0) ? -longint'(x) : longint'(x);
         ay = (y < 0) ? -longint'(y) : longint'(y);
         az = (z < 0) ? -longint'(z) : longint'(z);
         beat.face            = cubeuv_pkg::FACE_POS_X;
         beat.u_coord         = '0;
         beat.v_coord         = '0;
         beat.texture_present = 1'b0;
         beat.zero_direction  = 1'b0;
         if (ax == 0 && ay == 0 && az == 0) begin
            beat.zero_direction = 1'b1;
            return beat;
         end
         // Ties go to X first, then Y.
         if (ax >= ay && ax >= az) begin
            mag = ax;
            nv  = -longint'(y);
            if (x > 0) begin
               beat.face = cubeuv_pkg::FACE_POS_X;
               nu        = -longint'(z);
            end else begin
               beat.face = cubeuv_pkg::FACE_NEG_X;
               nu        = longint'(z);
            end
         end else if (ay >= az) begin
            mag = ay;
            nu  = longint'(x);
            if (y > 0) begin
               beat.face = cubeuv_pkg::FACE_POS_Y;
               nv        = longint'(z);
            end else begin
               beat.face = cubeuv_pkg::FACE_NEG_Y;
               nv        = -longint'(z);
            end
         end else begin
            mag = az;
            nv  = -longint'(y);
            if (z > 0) begin
               beat.face = cubeuv_pkg::FACE_POS_Z;
               nu        = longint'(x);
            end else begin
               beat.face = cubeuv_pkg::FACE_NEG_Z;
               nu        = -longint'(x);
            end
         end
         beat.u_coord         = face_coord(nu, mag);
         beat.v_coord         = face_coord(nv, mag);
         beat.texture_present = face_mask[beat.face];
         return beat;
      endfunction

      function void note_direction(shortint x, shortint y, shortint z);
         expected_q.push_back(predict_face_uv(x, y, z));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            if (mismatches < MAX_REPORTS)
               $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [2:0] face, logic [QB-1:0] u, logic [QB-1:0] v,
                                 logic tex, logic zero);
         face_uv_type want;
         if (expected_q.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $error("result beat with nothing outstanding: face %0d u %0d v %0d",
                      face, u, v);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("face_index", 32'(want.face), 32'(face));
         compare_field("u_coord", 32'(want.u_coord), 32'(u));
         compare_field("v_coord", 32'(want.v_coord), 32'(v));
         compare_field("texture_present", 32'(want.texture_present), 32'(tex));
         compare_field("zero_direction", 32'(want.zero_direction), 32'(zero));
      endfunction
   endclass

   // Every input has a known value from time zero.
   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           start     = 1'b0;
   logic [CB-1:0]  req_dir_x = '0;
   logic [CB-1:0]  req_dir_y = '0;
   logic [CB-1:0]  req_dir_z = '0;
   logic           csr_valid = 1'b0;
   logic [MB-1:0]  csr_wdata = '0;

   logic           busy;
   logic           rsp_valid;
   logic [2:0]     rsp_face_index;
   logic [QB-1:0]  rsp_u_coord;
   logic [QB-1:0]  rsp_v_coord;
   logic           rsp_texture_present;
   logic           rsp_zero_direction;
   logic           csr_ready;

   face_uv_scoreboard book = new();

   // Directed directions: the zero vector, one beat per face, ties of every
   // kind, the most negative component, and minors equal to plus or minus
   // the major magnitude, which give a coordinate of zero or a saturated one.
   localparam int DIRECTED_COUNT = 24;
   localparam int RESET_MASK_COUNT = 7;
   shortint dir_x_list [DIRECTED_COUNT] = '{
      0, 1, -1, 0, 0, 0, 0, 100, -100, 5, 3, -32768, -32768, 32767,
      32767, 1, 12345, -20000, 3, -7, 0, 32767, 0, 1};
   shortint dir_y_list [DIRECTED_COUNT] = '{
      0, 0, 0, 1, -1, 0, 0, 100, 100, -9, 7, 0, -32768, -32768,
      32767, -32768, -23456, 20000, 1, 3, 0, 32767, -32768, 2};
   shortint dir_z_list [DIRECTED_COUNT] = '{
      0, 0, 0, 0, 0, 1, -1, 100, -100, 9, -7, 0, -32768, 0,
      -32767, 32767, 32767, -32768, 2, -5, -32768, 32767, 0, 3};

   // Component values at the edges of the two's complement range.
   shortint corner_vals [8] = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};

   cube_map_face_uv_select u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_dir_x           (req_dir_x),
      .req_dir_y           (req_dir_y),
      .req_dir_z           (req_dir_z),
      .rsp_valid           (rsp_valid),
      .rsp_face_index      (rsp_face_index),
      .rsp_u_coord         (rsp_u_coord),
      .rsp_v_coord         (rsp_v_coord),
      .rsp_texture_present (rsp_texture_present),
      .rsp_zero_direction  (rsp_zero_direction),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A result beat is on the ports for one cycle only and cannot be held
   // off, so it is taken at every rising edge at which rsp_valid is high.
   // The values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         book.check_result(rsp_face_index, rsp_u_coord, rsp_v_coord,
                           rsp_texture_present, rsp_zero_direction);
   end

   // Mostly back to back or short gaps, now and then a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A component of the given magnitude with a random sign; a magnitude of
   // 32768 only exists as the most negative value.
   function automatic shortint signed_mag(int mag);
      if (mag >= 32768)
         return shortint'(-32768);
      if ($urandom_range(0, 1) == 1)
         return shortint'(-mag);
      return shortint'(mag);
   endfunction

   // Places the major component on one of the three axes.
   task automatic place_axes(input shortint major, input shortint a, input shortint b,
                             output shortint x, output shortint y, output shortint z);
      case ($urandom_range(0, 2))
         0: begin
            x = major; y = a; z = b;
         end
         1: begin
            x = a; y = major; z = b;
         end
         default: begin
            x = a; y = b; z = major;
         end
      endcase
   endtask

   task automatic random_direction(output shortint x, output shortint y,
                                   output shortint z);
      int      kind;
      int      mag;
      shortint a, b, c;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         // Fully random bits in every component.
         x = shortint'($urandom);
         y = shortint'($urandom);
         z = shortint'($urandom);
      end else if (kind < 42) begin
         // Tiny vectors: zeros, ties and small divisors come up often.
         x = shortint'($urandom_range(0, 16) - 8);
         y = shortint'($urandom_range(0, 16) - 8);
         z = shortint'($urandom_range(0, 16) - 8);
      end else if (kind < 57) begin
         // Two or three components share the largest magnitude.
         mag = $urandom_range(1, 32768);
         a   = signed_mag(mag);
         b   = signed_mag(mag);
         if ($urandom_range(0, 3) == 0)
            c = signed_mag(mag);
         else
            c = signed_mag($urandom_range(0, mag - 1));
         place_axes(c, a, b, x, y, z);
      end else if (kind < 70) begin
         // Minors within a step or two of the major magnitude.
         mag = $urandom_range(1, 32768);
         a   = signed_mag(mag);
         b   = signed_mag(mag - $urandom_range(0, (mag < 2) ? mag : 2));
         c   = signed_mag(mag - $urandom_range(0, (mag < 2) ? mag : 2));
         place_axes(a, b, c, x, y, z);
      end else if (kind < 84) begin
         x = corner_vals[$urandom_range(0, 7)];
         y = corner_vals[$urandom_range(0, 7)];
         z = corner_vals[$urandom_range(0, 7)];
      end else if (kind < 87) begin
         x = 0;
         y = 0;
         z = 0;
      end else begin
         // Small divisors with minors anywhere in range.
         mag = $urandom_range(1, 255);
         a   = signed_mag(mag);
         b   = shortint'($urandom_range(0, 2 * mag) - mag);
         c   = shortint'($urandom_range(0, 2 * mag) - mag);
         place_axes(a, b, c, x, y, z);
      end
   endtask

   // Presents one direction beat and waits until the block takes it. Start
   // is left high so that the next beat can follow on the very next cycle.
   task automatic send_dir(input shortint x, input shortint y, input shortint z);
      start     <= 1'b1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      do @(posedge clock); while (busy !== 1'b0);
      book.note_direction(x, y, z);
   endtask

   // Drops start for a number of cycles and puts junk on the idle data lines,
   // which the block must ignore.
   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start     <= 1'b0;
         req_dir_x <= CB'($urandom);
         req_dir_y <= CB'($urandom);
         req_dir_z <= CB'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (book.pending() != 0)
         @(posedge clock);
   endtask

   // The mask is only written with nothing in flight, since the front stage
   // reads it while a beat is taken.
   task automatic write_face_mask(input logic [MB-1:0] mask);
      wait_drained();
      repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mask;
      do @(posedge clock); while (csr_ready !== 1'b1);
      book.set_mask(mask);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int             gap;
      bit             steady;
      shortint        x, y, z;
      logic [MB-1:0]  mask;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats. The first ones run with the mask still at its reset
      // value, the rest after a mask with alternate faces set.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (i == RESET_MASK_COUNT)
            write_face_mask(6'h15);
         send_dir(dir_x_list[i], dir_y_list[i], dir_z_list[i]);
         gap = pick_gap();
         if (gap == 0 && (i == RESET_MASK_COUNT - 1 || i == DIRECTED_COUNT - 1))
            gap = 1;
         idle_gap(gap);
      end

      // Random phases, each under its own mask setting: all faces, none,
      // the other alternate set, then random masks, then all faces again.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: mask = 6'h3F;
            1: mask = 6'h00;
            2: mask = 6'h2A;
            5: mask = 6'h3F;
            default: mask = MB'($urandom_range(0, 63));
         endcase
         write_face_mask(mask);
         steady = 1'b0;
         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            // Every so often switch between a back to back stretch and a
            // stretch with random gaps.
            if (i % 40 == 0)
               steady = ($urandom_range(0, 3) == 0);
            random_direction(x, y, z);
            send_dir(x, y, z);
            gap = steady ? 0 : pick_gap();
            if (gap == 0 && i == BEATS_PER_PHASE - 1)
               gap = 1;
            idle_gap(gap);
         end
      end

      wait_drained();
      // Any stray result beat would show up within the chain's latency.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Far beyond the slowest correct run, which sends about 1700 beats with long gaps.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
